[design/assert_macros.svh]
// Assertion macros for the text frame controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[design/otfc_pkg.sv]
// Shared types, codes and tables for the text frame controller.
package otfc_pkg;
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_LINE  = 3'd1;
    localparam logic [2:0] CMD_CHAR  = 3'd2;
    localparam logic [2:0] CMD_FLUSH = 3'd3;
    localparam logic [2:0] CMD_INIT  = 3'd4;

    localparam logic [7:0] CTRL_CMD  = 8'h00;
    localparam logic [7:0] CTRL_DATA = 8'h40;

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_CLRP  = 3'd3;
    localparam logic [2:0] OP_CLRB  = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [8:0] addr;
        logic [7:0] wdata;
        logic [3:0] slot;
    } t_dp_cmd;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_dp_stat;

    function automatic logic [7:0] init_byte(input logic [4:0] i);
        logic [7:0] b;
        b = 8'h00;
        case (i)
            5'd0: b = 8'hAE;  5'd1: b = 8'hD5;  5'd2: b = 8'h80;  5'd3: b = 8'hA8;
            5'd4: b = 8'h1F;  5'd5: b = 8'hD3;  5'd6: b = 8'h00;  5'd7: b = 8'h40;
            5'd8: b = 8'h8D;  5'd9: b = 8'h14;  5'd10: b = 8'h20; 5'd11: b = 8'h02;
            5'd12: b = 8'hA1; 5'd13: b = 8'hC8; 5'd14: b = 8'hDA; 5'd15: b = 8'h02;
            5'd16: b = 8'h81; 5'd17: b = 8'h8F; 5'd18: b = 8'hD9; 5'd19: b = 8'hF1;
            5'd20: b = 8'hDB; 5'd21: b = 8'h40; 5'd22: b = 8'hA4; 5'd23: b = 8'hA6;
            5'd24: b = 8'hAF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [39:0] glyph(input logic [7:0] ch);
        logic [7:0] c;
        logic [39:0] g;
        c = ch;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        g = 40'h0609510102;
        case (c)
            8'h20: g = 40'h0000000000;
            8'h2D: g = 40'h0808080808;
            8'h2E: g = 40'h0000606000;
            8'h2F: g = 40'h0204081020;
            8'h30: g = 40'h3E4549513E;
            8'h31: g = 40'h00407F4200;
            8'h32: g = 40'h4649516142;
            8'h33: g = 40'h314B454121;
            8'h34: g = 40'h107F121418;
            8'h35: g = 40'h3945454527;
            8'h36: g = 40'h3049494A3C;
            8'h37: g = 40'h0305097101;
            8'h38: g = 40'h3649494936;
            8'h39: g = 40'h1E29494906;
            8'h3A: g = 40'h0000363600;
            8'h41: g = 40'h7E1111117E;
            8'h42: g = 40'h364949497F;
            8'h43: g = 40'h224141413E;
            8'h44: g = 40'h1C2241417F;
            8'h45: g = 40'h414949497F;
            8'h46: g = 40'h010909097F;
            8'h47: g = 40'h7A4949413E;
            8'h48: g = 40'h7F0808087F;
            8'h49: g = 40'h00417F4100;
            8'h4A: g = 40'h013F414020;
            8'h4B: g = 40'h412214087F;
            8'h4C: g = 40'h404040407F;
            8'h4D: g = 40'h7F020C027F;
            8'h4E: g = 40'h7F1008047F;
            8'h4F: g = 40'h3E4141413E;
            8'h50: g = 40'h060909097F;
            8'h51: g = 40'h5E2151413E;
            8'h52: g = 40'h462919097F;
            8'h53: g = 40'h3149494946;
            8'h54: g = 40'h01017F0101;
            8'h55: g = 40'h3F4040403F;
            8'h56: g = 40'h1F2040201F;
            8'h57: g = 40'h3F4038403F;
            8'h58: g = 40'h6314081463;
            8'h59: g = 40'h0708700807;
            8'h5A: g = 40'h4345495161;
            default: g = 40'h0609510102;
        endcase
        return g;
    endfunction
endpackage

[design/otfc_datapath.sv]
// Frame store memory and payload assembly register.
module otfc_datapath (
    input  logic              i_clk,
    input  otfc_pkg::t_dp_cmd i_cmd,
    output otfc_pkg::t_dp_stat o_stat
);
    import otfc_pkg::*;
    logic [7:0]   r_mem [512];
    logic [7:0]   r_rd;
    logic [3:0]   r_slot;
    logic         r_rdv;
    logic [127:0] r_pay;
    logic [127:0] n_pay;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WRITE) r_mem[i_cmd.addr] <= i_cmd.wdata;
        r_rd   <= r_mem[i_cmd.addr];
        r_slot <= i_cmd.slot;
        r_rdv  <= (i_cmd.op == OP_READ);
    end

    always_comb begin
        n_pay = r_pay;
        if (i_cmd.op == OP_CLRP) n_pay = '0;
        if (i_cmd.op == OP_CLRB) n_pay = {120'd0, i_cmd.wdata};
        if (r_rdv) n_pay[{r_slot, 3'd0} +: 8] = r_rd;
    end

    always_ff @(posedge i_clk) r_pay <= n_pay;

    assign o_stat.lo = r_pay[63:0];
    assign o_stat.hi = r_pay[127:64];
endmodule

[design/otfc_ctrl.sv]
// Command sequencer for the text frame controller.
module otfc_ctrl #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req,
    output logic              o_busy,
    input  logic [2:0]        i_command,
    input  logic [2:0]        i_line,
    input  logic [7:0]        i_character,
    output otfc_pkg::t_dp_cmd o_cmd,
    output logic              o_xfer,
    output logic [7:0]        o_ctrl,
    output logic [4:0]        o_len,
    output logic              o_last,
    input  logic              i_out_free
);
    import otfc_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_LCLR = 4'd2, S_CHAR = 4'd3,
                           S_FCMD = 4'd4, S_FRD = 4'd5, S_FWT = 4'd6, S_FEMIT = 4'd7,
                           S_INIT = 4'd8, S_WAIT = 4'd9;

    logic [3:0]  r_state, n_state;
    logic [9:0]  r_cnt, n_cnt;
    logic [1:0]  r_page, n_page;
    logic        r_valid, n_valid;
    logic [1:0]  r_cpage, n_cpage;
    logic [7:0]  r_ccol, n_ccol;
    logic [7:0]  r_ch, n_ch;
    logic [7:0]  r_base, n_base;
    logic [3:0]  r_ret, n_ret;
    logic [39:0] w_g;
    logic [7:0]  w_len;
    logic        w_lastp;

    assign w_g     = glyph(r_ch);
    assign w_len   = (8'(COLUMNS) - r_base > 8'd16) ? 8'd16 : 8'(COLUMNS) - r_base;
    assign w_lastp = ({1'b0, r_base} + 9'(w_len) >= 9'(COLUMNS));
    assign o_busy  = (r_state != S_IDLE);

    // reset starts a full clear of the frame store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_valid <= 1'b0;
            r_cpage <= '0;
            r_ccol  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_cpage <= n_cpage;
            r_ccol  <= n_ccol;
            r_cnt   <= n_cnt;
        end
        r_page <= n_page;
        r_ch   <= n_ch;
        r_base <= n_base;
        r_ret  <= n_ret;
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_page = r_page;
        n_valid = r_valid; n_cpage = r_cpage; n_ccol = r_ccol; n_ch = r_ch;
        n_base = r_base; n_ret = r_ret;
        o_cmd = '0; o_xfer = 1'b0; o_ctrl = CTRL_CMD; o_len = 5'd1; o_last = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_req) begin
                n_cnt = '0;
                n_ch  = i_character;
                n_page = '0;
                unique case (i_command)
                    CMD_CLEAR: n_state = S_CLR;
                    CMD_LINE: begin
                        if ({1'b0, i_line} >= 4'(PAGES)) n_valid = 1'b0;
                        else begin
                            n_cpage = i_line[1:0]; n_ccol = '0; n_valid = 1'b1;
                            n_page = i_line[1:0]; n_state = S_LCLR;
                        end
                    end
                    CMD_CHAR: if (i_character != 8'd0 && r_valid &&
                                  {1'b0, r_ccol} + 9'd6 <= 9'(COLUMNS))
                        n_state = S_CHAR;
                    CMD_FLUSH: n_state = S_FCMD;
                    CMD_INIT:  n_state = S_INIT;
                    default: ;
                endcase
            end
            S_CLR: begin
                o_cmd.op = OP_WRITE; o_cmd.addr = r_cnt[8:0];
                n_cnt = r_cnt + 10'd1;
                if (r_cnt == 10'd511) n_state = S_IDLE;
            end
            S_LCLR: begin
                o_cmd.op = OP_WRITE;
                o_cmd.addr = 9'((r_page * COLUMNS + r_cnt) & 511);
                n_cnt = r_cnt + 10'd1;
                if (r_cnt == 10'(COLUMNS - 1)) n_state = S_IDLE;
            end
            S_CHAR: begin
                o_cmd.op = OP_WRITE;
                o_cmd.addr = 9'((r_cpage * COLUMNS + r_ccol + r_cnt) & 511);
                o_cmd.wdata = (r_cnt < 10'd5) ? w_g[r_cnt[2:0]*8 +: 8] : 8'd0;
                n_cnt = r_cnt + 10'd1;
                if (r_cnt == 10'd5) begin
                    n_state = S_IDLE; n_ccol = r_ccol + 8'd6;
                end
            end
            S_FCMD: if (i_out_free) begin
                o_cmd.op = OP_CLRB;
                o_cmd.wdata = (r_cnt == 10'd0) ? (8'hB0 | {6'd0, r_page}) :
                              (r_cnt == 10'd1) ? 8'h00 : 8'h10;
                n_state = S_WAIT; n_ret = S_FCMD;
                n_cnt = r_cnt + 10'd1;
                if (r_cnt == 10'd2) begin n_ret = S_FRD; n_base = '0; n_cnt = '0; end
            end
            S_WAIT: begin
                o_xfer = 1'b1;
                n_state = r_ret;
                if (r_ret == S_FRD) o_cmd.op = OP_CLRP;
                if (r_ret == S_IDLE) o_last = 1'b1;
            end
            S_FRD: begin
                o_cmd.op = OP_READ; o_cmd.slot = r_cnt[3:0];
                o_cmd.addr = 9'((r_page * COLUMNS + r_base + r_cnt) & 511);
                n_cnt = r_cnt + 10'd1;
                if (r_cnt + 10'd1 == 10'(w_len)) n_state = S_FWT;
            end
            S_FWT: n_state = S_FEMIT;
            S_FEMIT: if (i_out_free) begin
                o_xfer = 1'b1; o_ctrl = CTRL_DATA; o_len = w_len[4:0];
                o_cmd.op = OP_CLRP; n_cnt = '0;
                n_base = r_base + w_len;
                if (w_lastp) begin
                    n_page = r_page + 2'd1;
                    n_state = S_FCMD;
                    if ({1'b0, r_page} == 3'(PAGES - 1)) begin
                        n_state = S_IDLE; o_last = 1'b1;
                    end
                end else n_state = S_FRD;
            end
            S_INIT: if (i_out_free) begin
                o_cmd.op = OP_CLRB; o_cmd.wdata = init_byte(r_cnt[4:0]);
                n_cnt = r_cnt + 10'd1; n_state = S_WAIT;
                n_ret = (r_cnt == 10'd24) ? S_IDLE : S_INIT;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[design/oled_text_frame_controller.sv]
// Top level of the text frame controller.
// Clear: writes all 512 frame RAM bytes. Start line: clears COLUMNS bytes. Put char: writes 6 bytes.
// Flush: per page three command transfers, then data chunks of up to 16 bytes read from frame RAM.
// Init: one transfer per init byte. A result waits in an output register.
// Synchronous active-low reset clears control state, address 0x3C, then the frame
// RAM is cleared at all 512 addresses, during which input is not ready.
module oled_text_frame_controller #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // command, line, character
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // bus_address, control_byte, length, low, high
    output logic         m_axis_tlast
);
    import otfc_pkg::*;
    `include "assert_macros.svh"
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic w_busy, w_xfer, w_last, w_req;
    logic [7:0] w_ctrl;
    logic [4:0] w_len;
    logic [6:0] r_addr;
    logic       r_ov;
    logic       r_olast;
    logic [7:0] r_octrl;
    logic [4:0] r_olen;
    logic [6:0] r_oaddr;
    logic [127:0] r_opay;

    assign s_axis_tready = !w_busy;
    assign w_req = s_axis_tvalid && s_axis_tready;

    otfc_ctrl #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_ctrl (
        .i_clk, .i_rst_n, .i_req(w_req), .o_busy(w_busy),
        .i_command(s_axis_tdata[2:0]), .i_line(s_axis_tdata[5:3]),
        .i_character(s_axis_tdata[13:6]), .o_cmd(w_cmd), .o_xfer(w_xfer),
        .o_ctrl(w_ctrl), .o_len(w_len), .o_last(w_last),
        .i_out_free(!r_ov || m_axis_tready)
    );
    otfc_datapath u_dp (.i_clk, .i_cmd(w_cmd), .o_stat(w_stat));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= 7'h3C; r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) r_addr <= i_cfg_wdata;
            if (w_xfer) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
        end
        if (w_xfer) begin
            r_olast <= w_last; r_octrl <= w_ctrl; r_olen <= w_len;
            r_oaddr <= r_addr; r_opay <= {w_stat.hi, w_stat.lo};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {3'd0, r_opay, r_olen, r_octrl, r_oaddr};

    `ASSERT_NEXT(a_xfer_sets_valid, i_clk, i_rst_n, w_xfer, m_axis_tvalid)
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, w_xfer && r_ov, m_axis_tready)
    `ASSERT_IMPL(a_busy_no_req, i_clk, i_rst_n, w_xfer, !s_axis_tready)
endmodule
